// File: sv/pairwise_repel_force_sum_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the pairwise repel force block
// Concurrent assertion wrappers that can be compiled out as a group.
// ----------------------------------------------------------------------------
`ifndef PAIRWISE_REPEL_FORCE_SUM_ASSERT_SVH
`define PAIRWISE_REPEL_FORCE_SUM_ASSERT_SVH

`ifndef NO_ASSERTIONS
// Checked on every clock edge outside reset.
`define PRFS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Checked on every clock edge, reset included.
`define PRFS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define PRFS_ASSERT(lbl, prop, msg)
`define PRFS_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// File: sv/prfs_pkg.sv
// ----------------------------------------------------------------------------
// prfs_pkg
// Types and constants shared by the pairwise repel force block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package prfs_pkg;

  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned POS_WIDTH_DEF = 32;

  localparam int unsigned REG_W    = 32;
  localparam int unsigned MAG_W    = 31;
  localparam int unsigned UNIT_W   = 64;
  localparam int unsigned ROOT_W   = 32;

  localparam int unsigned MUL_STEPS  = 32;
  localparam int unsigned SQRT_STEPS = 32;
  localparam int unsigned DIV_STEPS  = 64;
  localparam int unsigned CNT_W      = $clog2(DIV_STEPS);

  localparam logic [REG_W-1:0] REPEL_RESET = 32'd131072000;
  localparam logic [REG_W-1:0] CAP_RESET   = 32'd6553600;
  localparam logic [REG_W-1:0] MIN_RESET   = 32'd66;

  localparam logic [1:0] REG_REPEL = 2'd0;
  localparam logic [1:0] REG_CAP   = 2'd1;
  localparam logic [1:0] REG_MIN   = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_XX,
    ST_MUL_YY,
    ST_CHECK,
    ST_SQRT,
    ST_DIV_SCALE,
    ST_MUL_CX,
    ST_DIV_CX,
    ST_MUL_CY,
    ST_DIV_CY,
    ST_FINISH
  } state_e;

endpackage

// File: sv/pairwise_repel_force_sum.sv
// ----------------------------------------------------------------------------
// pairwise_repel_force_sum
// Accumulates the repulsive force on one body over a run of neighbors.
// ----------------------------------------------------------------------------
//  channel  direction  payload
//  s_axis   in         tdata {other_y, other_x, self_y, self_x}, tuser counts,
//                      tlast last_neighbour
//  m_axis   out        tdata {force_y, force_x}, tuser saturated
//  cfg      in         write enable, register index, 32-bit data
//
//  A counted pair runs four 32-step shift-add multiplies,
//  a 32-step square root and three 64-step restoring divisions, all through
//  one shared multiplier, one root unit and one divider, one bit per step.
//  A pair dropped at the distance check, or an uncounted item, goes to finish.
//  Input is taken only while the sequencer is idle; a result waits in the
//  output register, and a new run may start while it waits.
//  Reset clears sums, flags and registers to their defaults at once.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "pairwise_repel_force_sum_assert.svh"

module pairwise_repel_force_sum
  import prfs_pkg::*;
#(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF,
  parameter int unsigned POS_WIDTH = POS_WIDTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_idx_i,
  input  logic [REG_W-1:0]     cfg_data_i,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // self_x, self_y, other_x, other_y from bit 0 up, zero padded
  input  logic [((4*POS_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  // counts
  input  logic                 s_axis_tuser,
  input  logic                 s_axis_tlast,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // force_x, force_y from bit 0 up
  output logic [63:0]          m_axis_tdata,
  // saturated
  output logic                 m_axis_tuser
);

  localparam int unsigned DW = POS_WIDTH + 1;

  state_e state_q, state_d;

  logic [REG_W-1:0] repel_q, cap_q, min_q;
  logic [MAG_W-1:0] ax_q, ay_q;
  logic             nx_q, ny_q, last_q;
  logic [CNT_W-1:0] cnt_q;

  logic [UNIT_W-1:0] ma_q, macc_q, s_q;
  logic [REG_W-1:0]  mb_q, scale_q;
  logic [UNIT_W-1:0] sn_q;
  logic [33:0]       srem_q;
  logic [ROOT_W-1:0] root_q, dist_q;
  logic [UNIT_W-1:0] dn_q, dd_q, dq_q;
  logic [UNIT_W:0]   dr_q;

  logic signed [REG_W-1:0] sum_x_q, sum_y_q;
  logic                    sat_q;
  logic                    m_valid_q, m_sat_q;
  logic [63:0]             m_data_q;

  // Input differences and clipped magnitudes.
  logic signed [DW-1:0] dx, dy;
  logic [DW-1:0]        mx, my;
  logic [MAG_W-1:0]     cx_mag, cy_mag;

  always_comb begin
    dx = DW'($signed(s_axis_tdata[POS_WIDTH-1:0]))
       - DW'($signed(s_axis_tdata[2*POS_WIDTH +: POS_WIDTH]));
    dy = DW'($signed(s_axis_tdata[POS_WIDTH +: POS_WIDTH]))
       - DW'($signed(s_axis_tdata[3*POS_WIDTH +: POS_WIDTH]));
    mx = dx[DW-1] ? DW'(-dx) : DW'(dx);
    my = dy[DW-1] ? DW'(-dy) : DW'(dy);
    cx_mag = (UNIT_W'(mx) > UNIT_W'({MAG_W{1'b1}})) ? {MAG_W{1'b1}} : MAG_W'(mx);
    cy_mag = (UNIT_W'(my) > UNIT_W'({MAG_W{1'b1}})) ? {MAG_W{1'b1}} : MAG_W'(my);
  end

  // One step of each serial unit.
  logic [UNIT_W-1:0] mul_next;
  logic [35:0]       sq_t, sq_trial;
  logic              sq_take;
  logic [33:0]       srem_next;
  logic [ROOT_W-1:0] root_next;
  logic [UNIT_W:0]   dv_t;
  logic              dv_take;
  logic [UNIT_W:0]   dr_next;
  logic [UNIT_W-1:0] dq_next;
  logic [UNIT_W-1:0] d2;

  always_comb begin
    mul_next  = macc_q + (mb_q[0] ? ma_q : '0);
    sq_t      = {srem_q, sn_q[UNIT_W-1 -: 2]};
    sq_trial  = {2'b00, root_q, 2'b01};
    sq_take   = sq_t >= sq_trial;
    srem_next = sq_take ? 34'(sq_t - sq_trial) : 34'(sq_t);
    root_next = {root_q[ROOT_W-2:0], sq_take};
    dv_t      = {dr_q[UNIT_W-1:0], dn_q[UNIT_W-1]};
    dv_take   = dv_t >= {1'b0, dd_q};
    dr_next   = dv_take ? (dv_t - {1'b0, dd_q}) : dv_t;
    dq_next   = {dq_q[UNIT_W-2:0], dv_take};
    d2        = s_q >> FRAC_BITS;
  end

  // Saturating accumulate of one signed component.
  logic [32:0]       cmag;
  logic signed [34:0] acc_in, acc_r;
  logic              acc_neg, acc_hi, acc_lo;
  logic signed [REG_W-1:0] acc_out;

  always_comb begin
    cmag    = dq_next[32:0];
    acc_neg = (state_q == ST_DIV_CY) ? ny_q : nx_q;
    acc_in  = (state_q == ST_DIV_CY) ? 35'(sum_y_q) : 35'(sum_x_q);
    acc_r   = acc_neg ? acc_in - $signed({2'b00, cmag}) : acc_in + $signed({2'b00, cmag});
    acc_hi  = acc_r > 35'sd2147483647;
    acc_lo  = acc_r < -35'sd2147483648;
    acc_out = acc_hi ? 32'sh7fffffff : (acc_lo ? 32'sh80000000 : REG_W'(acc_r));
  end

  logic last_step_mul, last_step_sqrt, last_step_div;
  assign last_step_mul  = cnt_q == CNT_W'(MUL_STEPS - 1);
  assign last_step_sqrt = cnt_q == CNT_W'(SQRT_STEPS - 1);
  assign last_step_div  = cnt_q == CNT_W'(DIV_STEPS - 1);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid && s_axis_tready) begin
          state_d = s_axis_tuser ? ST_MUL_XX : ST_FINISH;
        end
      end
      ST_MUL_XX:    if (last_step_mul) state_d = ST_MUL_YY;
      ST_MUL_YY:    if (last_step_mul) state_d = ST_CHECK;
      ST_CHECK:     state_d = (d2 <= UNIT_W'(min_q)) ? ST_FINISH : ST_SQRT;
      ST_SQRT:      if (last_step_sqrt) state_d = ST_DIV_SCALE;
      ST_DIV_SCALE: if (last_step_div) state_d = ST_MUL_CX;
      ST_MUL_CX:    if (last_step_mul) state_d = ST_DIV_CX;
      ST_DIV_CX:    if (last_step_div) state_d = ST_MUL_CY;
      ST_MUL_CY:    if (last_step_mul) state_d = ST_DIV_CY;
      ST_DIV_CY:    if (last_step_div) state_d = ST_FINISH;
      ST_FINISH: begin
        if (!last_q || !m_valid_q || m_axis_tready) begin
          state_d = ST_IDLE;
        end
      end
      default:      state_d = ST_IDLE;
    endcase
  end

  // Handshake outputs.
  logic out_load;
  always_comb begin
    s_axis_tready = (state_q == ST_IDLE);
    out_load      = (state_q == ST_FINISH) && last_q && (!m_valid_q || m_axis_tready);
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_sat_q;

  // Control state and configuration.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      repel_q   <= REPEL_RESET;
      cap_q     <= CAP_RESET;
      min_q     <= MIN_RESET;
      sum_x_q   <= '0;
      sum_y_q   <= '0;
      sat_q     <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q != state_d) begin
        cnt_q <= '0;
      end else begin
        cnt_q <= cnt_q + CNT_W'(1);
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_REPEL: repel_q <= cfg_data_i;
          REG_CAP:   cap_q   <= cfg_data_i;
          REG_MIN:   min_q   <= cfg_data_i;
          default:   ;
        endcase
      end
      if ((state_q == ST_DIV_CX) && last_step_div) begin
        sum_x_q <= acc_out;
        if (acc_hi || acc_lo) sat_q <= 1'b1;
      end
      if ((state_q == ST_DIV_CY) && last_step_div) begin
        sum_y_q <= acc_out;
        if (acc_hi || acc_lo) sat_q <= 1'b1;
      end
      if (out_load) begin
        m_valid_q <= 1'b1;
        sum_x_q   <= '0;
        sum_y_q   <= '0;
        sat_q     <= 1'b0;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // Serial datapath.
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      m_data_q <= {sum_y_q, sum_x_q};
      m_sat_q  <= sat_q;
    end
    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid && s_axis_tready) begin
          ax_q       <= cx_mag;
          ay_q       <= cy_mag;
          nx_q       <= dx[DW-1];
          ny_q       <= dy[DW-1];
          last_q     <= s_axis_tlast;
          ma_q       <= UNIT_W'(cx_mag);
          mb_q       <= REG_W'(cx_mag);
          macc_q     <= '0;
        end
      end
      ST_MUL_XX, ST_MUL_YY, ST_MUL_CX, ST_MUL_CY: begin
        if (last_step_mul) begin
          case (state_q)
            ST_MUL_XX: begin
              s_q    <= mul_next;
              ma_q   <= UNIT_W'(ay_q);
              mb_q   <= REG_W'(ay_q);
              macc_q <= '0;
            end
            ST_MUL_YY: begin
              s_q <= s_q + mul_next;
            end
            default: begin
              // Product over the root.
              dn_q <= mul_next;
              dd_q <= UNIT_W'(dist_q);
              dr_q <= '0;
              dq_q <= '0;
            end
          endcase
        end else begin
          macc_q <= mul_next;
          ma_q   <= {ma_q[UNIT_W-2:0], 1'b0};
          mb_q   <= {1'b0, mb_q[REG_W-1:1]};
        end
      end
      ST_CHECK: begin
        sn_q   <= s_q;
        srem_q <= '0;
        root_q <= '0;
      end
      ST_SQRT: begin
        sn_q   <= {sn_q[UNIT_W-3:0], 2'b00};
        srem_q <= srem_next;
        root_q <= root_next;
        if (last_step_sqrt) begin
          dist_q <= root_next;
          dn_q   <= UNIT_W'(repel_q) << FRAC_BITS;
          dd_q   <= d2;
          dr_q   <= '0;
          dq_q   <= '0;
        end
      end
      ST_DIV_SCALE, ST_DIV_CX, ST_DIV_CY: begin
        dn_q <= {dn_q[UNIT_W-2:0], 1'b0};
        dr_q <= dr_next;
        dq_q <= dq_next;
        if (last_step_div) begin
          if (state_q == ST_DIV_SCALE) begin
            scale_q <= (dq_next > UNIT_W'(cap_q)) ? cap_q : REG_W'(dq_next);
            ma_q    <= UNIT_W'(ax_q);
            mb_q    <= (dq_next > UNIT_W'(cap_q)) ? cap_q : REG_W'(dq_next);
            macc_q  <= '0;
          end else if (state_q == ST_DIV_CX) begin
            ma_q   <= UNIT_W'(ay_q);
            mb_q   <= scale_q;
            macc_q <= '0;
          end
        end
      end
      default: ;
    endcase
  end

  `PRFS_ASSERT(a_skip_uncounted,
    (s_axis_tvalid && s_axis_tready && !s_axis_tuser) |=> (state_q == ST_FINISH),
    "uncounted neighbor did not go straight to finish")
  `PRFS_ASSERT(a_check_exit,
    (state_q == ST_CHECK) |=> (state_q == ST_FINISH || state_q == ST_SQRT),
    "distance check left to an unexpected state")
  `PRFS_ASSERT(a_dist_nonzero,
    (state_q == ST_DIV_CX || state_q == ST_DIV_CY) |-> (dist_q != '0),
    "division by a zero distance")
  `PRFS_ASSERT(a_result_issued,
    (state_q == ST_FINISH && last_q && !m_valid_q) |=> m_valid_q,
    "last neighbor finished without a result")
  `PRFS_ASSERT_ALWAYS(a_ready_idle,
    s_axis_tready |-> (state_q == ST_IDLE),
    "input accepted while a pair is in progress")

endmodule
